// ----- rtl/jsu_pkg.sv -----
// Shared types, constants and helper functions for the JSON string unescaper.
// Used by the channel interfaces and every module of the block.
package jsu_pkg;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 16;
	localparam int MAX_RES = 3;

	localparam logic [COUNT_W-1:0] CAP_RESET = 16'd256;
	localparam logic [COUNT_W:0]   ELEM_GUARD = 17'd5;
	localparam logic [COUNT_W:0]   UNI_GUARD  = 17'd4;

	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_APOS   = 8'h27;
	localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
	localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
	localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
	localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
	localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
	localparam logic [BYTE_W-1:0] CH_U      = 8'h75;

	localparam logic [BYTE_W-1:0] CTL_BS = 8'h08;
	localparam logic [BYTE_W-1:0] CTL_FF = 8'h0C;

	localparam logic [15:0]       UTF_ONE_LIMIT = 16'h0080;
	localparam logic [15:0]       UTF_TWO_LIMIT = 16'h0800;
	localparam logic [BYTE_W-1:0] UTF_LEAD2     = 8'hC0;
	localparam logic [BYTE_W-1:0] UTF_LEAD3     = 8'hE0;
	localparam logic [BYTE_W-1:0] UTF_CONT      = 8'h80;
	localparam logic [5:0]        UTF_LOW_MASK  = 6'h3F;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_STR,
		MODE_ESC,
		MODE_HEX
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_DONE,
		KIND_ERR
	} kind_t;

	typedef struct packed {
		mode_t              mode;
		logic [1:0]         hex_seen;
		logic [15:0]        code_point;
		logic [COUNT_W-1:0] byte_count;
	} state_t;

	typedef struct packed {
		logic [1:0]                     count;
		kind_t                          kind;
		logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
		logic [COUNT_W-1:0]             length;
	} group_t;

	// Returns a valid flag in the top bit and the digit value below it.
	function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

// ----- rtl/jsu_ifs.sv -----
// Channel interfaces of the JSON string unescaper: text in, results out, configuration.
// Depends on jsu_pkg.
interface jsu_text_if;
	import jsu_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface jsu_result_if;
	import jsu_pkg::*;
	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  out_byte;
	kind_t              kind;
	logic [COUNT_W-1:0] str_length;
	logic               last;
	modport source (output valid, output out_byte, output kind, output str_length,
		output last, input ready);
	modport sink (input valid, input out_byte, input kind, input str_length,
		input last, output ready);
endinterface

interface jsu_cfg_if;
	import jsu_pkg::*;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] out_capacity;
	modport source (output valid, output out_capacity, input ready);
	modport sink (input valid, input out_capacity, output ready);
endinterface

// ----- rtl/jsu_decode.sv -----
// Combinational decode step: one text byte and the current state give the next
// state and a group of up to three results. Depends on jsu_pkg.
module jsu_decode (
	input  logic [7:0]       in_byte,
	input  jsu_pkg::state_t  cur,
	input  logic [15:0]      capacity,
	output jsu_pkg::state_t  nxt,
	output jsu_pkg::group_t  grp
);
	import jsu_pkg::*;

	logic               elem_full;
	logic               uni_full;
	logic [4:0]         hv;
	logic [15:0]        cp_new;
	state_t             idle_st;

	assign elem_full = ({1'b0, cur.byte_count} + ELEM_GUARD) >= {1'b0, capacity};
	assign uni_full  = ({1'b0, cur.byte_count} + UNI_GUARD) >= {1'b0, capacity};
	assign hv        = hex_value(in_byte);
	assign cp_new    = {cur.code_point[11:0], hv[3:0]};

	always_comb begin
		idle_st            = '0;
		idle_st.mode       = MODE_IDLE;
		nxt                = cur;
		grp                = '0;
		grp.kind           = KIND_DATA;
		case (cur.mode)
			MODE_IDLE: begin
				if (in_byte == CH_QUOTE) begin
					nxt      = idle_st;
					nxt.mode = MODE_STR;
				end else if (in_byte != CH_SPACE && in_byte != CH_TAB &&
					in_byte != CH_CR && in_byte != CH_LF) begin
					nxt       = idle_st;
					grp.count = 2'd1;
					grp.kind  = KIND_ERR;
				end
			end
			MODE_STR: begin
				if (in_byte == CH_NUL) begin
					nxt       = idle_st;
					grp.count = 2'd1;
					grp.kind  = KIND_ERR;
				end else if (in_byte == CH_QUOTE) begin
					nxt        = idle_st;
					grp.count  = 2'd1;
					grp.kind   = KIND_DONE;
					grp.length = cur.byte_count;
				end else if (elem_full) begin
					nxt       = idle_st;
					grp.count = 2'd1;
					grp.kind  = KIND_ERR;
				end else if (in_byte == CH_BSLASH) begin
					nxt.mode = MODE_ESC;
				end else begin
					grp.count    = 2'd1;
					grp.bytes[0] = in_byte;
					nxt.byte_count = cur.byte_count + 16'd1;
				end
			end
			MODE_ESC: begin
				nxt.mode       = MODE_STR;
				grp.count      = 2'd1;
				nxt.byte_count = cur.byte_count + 16'd1;
				case (in_byte)
					CH_QUOTE, CH_APOS, CH_BSLASH, CH_SLASH: grp.bytes[0] = in_byte;
					CH_B: grp.bytes[0] = CTL_BS;
					CH_F: grp.bytes[0] = CTL_FF;
					CH_N: grp.bytes[0] = CH_LF;
					CH_R: grp.bytes[0] = CH_CR;
					CH_T: grp.bytes[0] = CH_TAB;
					CH_U: begin
						nxt            = cur;
						nxt.mode       = MODE_HEX;
						nxt.hex_seen   = 2'd0;
						nxt.code_point = '0;
						grp.count      = 2'd0;
					end
					default: begin
						nxt       = idle_st;
						grp.count = 2'd1;
						grp.kind  = KIND_ERR;
					end
				endcase
			end
			default: begin
				if (!hv[4]) begin
					nxt       = idle_st;
					grp.count = 2'd1;
					grp.kind  = KIND_ERR;
				end else if (cur.hex_seen != 2'd3) begin
					nxt.code_point = cp_new;
					nxt.hex_seen   = cur.hex_seen + 2'd1;
				end else if (uni_full) begin
					nxt       = idle_st;
					grp.count = 2'd1;
					grp.kind  = KIND_ERR;
				end else begin
					nxt.mode       = MODE_STR;
					nxt.hex_seen   = 2'd0;
					nxt.code_point = '0;
					if (cp_new < UTF_ONE_LIMIT) begin
						grp.count      = 2'd1;
						grp.bytes[0]   = cp_new[7:0];
						nxt.byte_count = cur.byte_count + 16'd1;
					end else if (cp_new < UTF_TWO_LIMIT) begin
						grp.count      = 2'd2;
						grp.bytes[0]   = UTF_LEAD2 | {3'b000, cp_new[10:6]};
						grp.bytes[1]   = UTF_CONT | {2'b00, cp_new[5:0] & UTF_LOW_MASK};
						nxt.byte_count = cur.byte_count + 16'd2;
					end else begin
						grp.count      = 2'd3;
						grp.bytes[0]   = UTF_LEAD3 | {4'b0000, cp_new[15:12]};
						grp.bytes[1]   = UTF_CONT | {2'b00, cp_new[11:6] & UTF_LOW_MASK};
						grp.bytes[2]   = UTF_CONT | {2'b00, cp_new[5:0] & UTF_LOW_MASK};
						nxt.byte_count = cur.byte_count + 16'd3;
					end
				end
			end
		endcase
	end

endmodule

// ----- rtl/jsu_serializer.sv -----
// Result register that holds one group of results and hands them out one per cycle while the receiver is ready.
// Depends on jsu_pkg and jsu_ifs.
module jsu_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  jsu_pkg::group_t     grp,
	output logic                can_load,
	jsu_result_if.source        result
);
	import jsu_pkg::*;

	group_t     grp_s2;
	logic       v_s2;
	logic [1:0] idx_q;
	logic       is_last;
	logic       fire;

	assign is_last  = (idx_q == grp_s2.count - 2'd1);
	assign fire     = v_s2 && result.ready;
	assign can_load = !v_s2 || (fire && is_last);

	assign result.valid      = v_s2;
	assign result.out_byte   = grp_s2.bytes[idx_q];
	assign result.kind       = grp_s2.kind;
	assign result.str_length = grp_s2.length;
	assign result.last       = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			v_s2  <= (grp.count != 2'd0);
			idx_q <= 2'd0;
		end else if (fire) begin
			if (is_last) begin
				v_s2  <= 1'b0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s2 <= grp;
		end
	end

endmodule

// ----- rtl/json_string_unescaper_unit.sv -----
// Top level of the streaming JSON string unescaper.
// Depends on jsu_pkg, jsu_ifs, jsu_decode and jsu_serializer.
//
// Usage:
// Text bytes enter on the text channel, one item per byte, accepted when valid and
// ready are both high. Each byte yields zero to three result items on the result
// channel: decoded data bytes, a done item with the string length, or an error item.
// The last result caused by one byte carries last high.
// The cfg channel writes out_capacity; it is always ready and should only be
// written while no bytes are in flight.
// An accepted byte waits in the byte stage, is decoded, and its results are loaded into
// the result register. Throughput is one byte per cycle while the receiver keeps up; a
// byte that decodes to two or three UTF-8 bytes holds the result register until all of
// them have left through the one result port.
// A byte stage and a result register separate the two sides, so a new byte is taken
// while a finished result still waits. When the receiver stalls, results hold
// steady and text ready drops once both stages are full.
// Reset clears all state to idle and sets out_capacity to 256.
module json_string_unescaper_unit (
	input  logic         clk,
	input  logic         arst_n,
	jsu_text_if.sink     text,
	jsu_result_if.source result,
	jsu_cfg_if.sink      cfg
);
	import jsu_pkg::*;

	logic [BYTE_W-1:0]  byte_s1;
	logic               v_s1;
	state_t             state_q;
	state_t             state_nxt;
	logic [COUNT_W-1:0] cap_q;
	group_t             grp;
	logic               can_load;
	logic               adv;

	assign adv        = v_s1 && can_load;
	assign text.ready = !v_s1 || can_load;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			state_q.mode <= MODE_IDLE;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cap_q <= cfg.out_capacity;
		end
	end

	jsu_decode u_decode (
		.in_byte  (byte_s1),
		.cur      (state_q),
		.capacity (cap_q),
		.nxt      (state_nxt),
		.grp      (grp)
	);

	jsu_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.grp      (grp),
		.can_load (can_load),
		.result   (result)
	);

endmodule

// ----- test/json_string_unescaper_unit_tb.sv -----
// Self-checking testbench for json_string_unescaper_unit: random and directed JSON text
// with random stalls on both channels, results checked against an in-bench decoder.
// Depends on jsu_pkg, the channel interfaces in jsu_ifs and the unit itself.
`timescale 1ns / 1ps

module json_string_unescaper_unit_tb;
	import jsu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 200;

	localparam logic [7:0] ESC_LETTERS [9] = '{CH_QUOTE, CH_APOS, CH_BSLASH, CH_SLASH,
		CH_B, CH_F, CH_N, CH_R, CH_T};
	localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
	localparam logic [7:0] DIRECTED [25] = '{"x", CH_NUL, CH_SPACE, CH_TAB, CH_CR, CH_LF,
		CH_QUOTE, 8'hFF, CH_BSLASH, CH_N, CH_BSLASH, CH_U, "0", "7", "F", "f",
		CH_BSLASH, CH_U, "F", "F", "F", "F", CH_QUOTE, CH_QUOTE, CH_NUL};

	typedef struct {
		logic [7:0] b;
		int         gap;
	} text_item_t;

	typedef struct {
		logic [7:0]  b;
		kind_t       kind;
		logic [15:0] len;
		logic        last;
	} result_t;

	logic clk;
	logic arst_n;

	jsu_text_if   text_ch ();
	jsu_result_if res_ch ();
	jsu_cfg_if    cfg_ch ();

	json_string_unescaper_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	text_item_t text_pend [$];
	result_t    expected_results [$];

	mode_t       dec_mode  = MODE_IDLE;
	logic [1:0]  dec_hex_n = '0;
	logic [15:0] dec_cp    = '0;
	logic [15:0] dec_len   = '0;
	logic [15:0] cap_now   = CAP_RESET;

	int  queued          = 0;
	int  items_sent      = 0;
	int  results_seen    = 0;
	int  fails           = 0;
	int  settings_run    = 1;
	int  cycle_count     = 0;
	int  tx_wait         = 0;
	int  rx_wait         = 0;
	int  rx_gap;
	bit  tx_fast         = 0;
	bit  tx_burst        = 0;
	bit  rx_fast         = 0;
	bit  hold_req        = 0;
	bit  hold_done       = 0;
	text_item_t tx_next;
	result_t    want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void put_result(input logic [7:0] b, input kind_t k,
		input logic [15:0] len);
		result_t r;
		r.b    = b;
		r.kind = k;
		r.len  = len;
		r.last = 1'b0;
		expected_results.push_back(r);
	endfunction

	function automatic void put_data(input logic [7:0] b);
		put_result(b, KIND_DATA, '0);
		dec_len = dec_len + 16'd1;
	endfunction

	function automatic void to_idle();
		dec_mode  = MODE_IDLE;
		dec_hex_n = '0;
		dec_cp    = '0;
		dec_len   = '0;
	endfunction

	function automatic void string_error();
		to_idle();
		put_result(8'h00, KIND_ERR, '0);
	endfunction

	function automatic void decode_byte(input logic [7:0] c);
		int n0;
		int d;
		n0 = expected_results.size();
		case (dec_mode)
			MODE_IDLE: begin
				if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
				end else if (c == CH_QUOTE) begin
					to_idle();
					dec_mode = MODE_STR;
				end else begin
					string_error();
				end
			end
			MODE_STR: begin
				if (c == CH_NUL) begin
					string_error();
				end else if (c == CH_QUOTE) begin
					put_result(8'h00, KIND_DONE, dec_len);
					to_idle();
				end else if ({1'b0, dec_len} + ELEM_GUARD >= {1'b0, cap_now}) begin
					string_error();
				end else if (c == CH_BSLASH) begin
					dec_mode = MODE_ESC;
				end else begin
					put_data(c);
				end
			end
			MODE_ESC: begin
				dec_mode = MODE_STR;
				case (c)
					CH_QUOTE, CH_APOS, CH_BSLASH, CH_SLASH: put_data(c);
					CH_B: put_data(CTL_BS);
					CH_F: put_data(CTL_FF);
					CH_N: put_data(CH_LF);
					CH_R: put_data(CH_CR);
					CH_T: put_data(CH_TAB);
					CH_U: begin
						dec_mode  = MODE_HEX;
						dec_hex_n = '0;
						dec_cp    = '0;
					end
					default: string_error();
				endcase
			end
			default: begin
				d = -1;
				if (c >= "0" && c <= "9") begin
					d = c - "0";
				end else if (c >= "a" && c <= "f") begin
					d = c - "a" + 10;
				end else if (c >= "A" && c <= "F") begin
					d = c - "A" + 10;
				end
				if (d < 0) begin
					string_error();
				end else begin
					dec_cp = {dec_cp[11:0], 4'(d)};
					if (dec_hex_n < 2'd3) begin
						dec_hex_n = dec_hex_n + 2'd1;
					end else begin
						dec_hex_n = '0;
						if ({1'b0, dec_len} + UNI_GUARD >= {1'b0, cap_now}) begin
							string_error();
						end else begin
							dec_mode = MODE_STR;
							if (dec_cp < UTF_ONE_LIMIT) begin
								put_data(dec_cp[7:0]);
							end else if (dec_cp < UTF_TWO_LIMIT) begin
								put_data(UTF_LEAD2 | 8'(dec_cp >> 6));
								put_data(UTF_CONT | {2'b00, dec_cp[5:0]});
							end else begin
								put_data(UTF_LEAD3 | 8'(dec_cp >> 12));
								put_data(UTF_CONT | {2'b00, dec_cp[11:6]});
								put_data(UTF_CONT | {2'b00, dec_cp[5:0]});
							end
							dec_cp = '0;
						end
					end
				end
			end
		endcase
		if (expected_results.size() > n0) begin
			expected_results[expected_results.size() - 1].last = 1'b1;
		end
	endfunction

	task automatic add_byte(input logic [7:0] b);
		text_item_t t;
		t.b   = b;
		t.gap = (tx_fast || tx_burst) ? 0 : $urandom_range(0, 16);
		text_pend.push_back(t);
		queued++;
	endtask

	task automatic add_plain();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(1, 255));
		end while (b == CH_QUOTE || b == CH_BSLASH);
		add_byte(b);
	endtask

	task automatic add_hex_digit(input logic [3:0] nib);
		if (nib < 4'd10) begin
			add_byte(8'("0" + nib));
		end else if ($urandom_range(0, 1)) begin
			add_byte(8'("A" + nib - 10));
		end else begin
			add_byte(8'("a" + nib - 10));
		end
	endtask

	task automatic add_string();
		logic [15:0] cp;
		repeat ($urandom_range(0, 2)) add_byte(BLANKS[$urandom_range(0, 3)]);
		add_byte(CH_QUOTE);
		repeat ($urandom_range(0, 10)) begin
			case ($urandom_range(0, 5))
				0, 1, 2: add_plain();
				3, 4: begin
					add_byte(CH_BSLASH);
					add_byte(ESC_LETTERS[$urandom_range(0, 8)]);
				end
				default: begin
					case ($urandom_range(0, 3))
						0: cp = 16'($urandom_range(0, 16'h007F));
						1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
						2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
						default: cp = 16'($urandom);
					endcase
					add_byte(CH_BSLASH);
					add_byte(CH_U);
					for (int i = 3; i >= 0; i--) add_hex_digit(cp[4*i +: 4]);
				end
			endcase
		end
		add_byte(CH_QUOTE);
	endtask

	task automatic add_noise();
		logic [7:0] b;
		bit ok;
		case ($urandom_range(0, 4))
			0: add_byte(8'($urandom));
			1: begin
				add_byte(CH_QUOTE);
				repeat ($urandom_range(0, 3)) add_plain();
				add_byte(CH_BSLASH);
				do begin
					b  = 8'($urandom);
					ok = (b != CH_U);
					foreach (ESC_LETTERS[i]) if (b == ESC_LETTERS[i]) ok = 1'b0;
				end while (!ok);
				add_byte(b);
			end
			2: begin
				add_byte(CH_QUOTE);
				add_byte(CH_BSLASH);
				add_byte(CH_U);
				repeat ($urandom_range(0, 3)) add_hex_digit(4'($urandom));
				do begin
					b = 8'($urandom);
				end while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
					(b >= "A" && b <= "F"));
				add_byte(b);
			end
			3: begin
				add_byte(CH_QUOTE);
				repeat ($urandom_range(0, 4)) add_plain();
				add_byte(CH_NUL);
			end
			default: repeat ($urandom_range(1, 3)) add_byte(BLANKS[$urandom_range(0, 3)]);
		endcase
	endtask

	task automatic add_random(input int n);
		int stop;
		stop = queued + n;
		while (queued < stop) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) != 0) begin
				add_string();
			end else begin
				add_noise();
			end
		end
		tx_burst = 1'b0;
	endtask

	task automatic settle();
		do begin
			@(posedge clk);
		end while (text_pend.size() != 0 || text_ch.valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] v);
		cfg_ch.valid        <= 1'b1;
		cfg_ch.out_capacity <= v;
		do begin
			@(posedge clk);
		end while (!cfg_ch.ready);
		cap_now = v;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_setting(input logic [15:0] cap, input bit fast_tx, input bit fast_rx,
		input bit hold, input int n);
		settle();
		write_capacity(cap);
		settings_run++;
		tx_fast = fast_tx;
		rx_fast = fast_rx;
		if (hold) begin
			hold_req = 1'b1;
		end
		add_random(n);
	endtask

	initial begin
		text_ch.valid       = 1'b0;
		text_ch.in_byte     = '0;
		res_ch.ready        = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.out_capacity = '0;
		arst_n              = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i]) add_byte(DIRECTED[i]);
		add_random(30);
		run_setting(16'hFFFF, 1'b1, 1'b0, 1'b1, 35);
		run_setting(16'd12, 1'b0, 1'b0, 1'b0, 25);
		run_setting(16'd0, 1'b0, 1'b1, 1'b0, 12);
		run_setting(16'd6, 1'b0, 1'b0, 1'b0, 12);
		run_setting(16'd5, 1'b1, 1'b1, 1'b0, 8);
		run_setting(CAP_RESET, 1'b1, 1'b1, 1'b0, 10);
		settle();
		repeat (10) @(posedge clk);
		$display("Sent %0d text items and checked %0d results over %0d capacity settings.",
			items_sent, results_seen, settings_run);
		$display("Capacities 0, 5, 6, 12, 256 and 65535 were used, with one long result stall.");
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			text_ch.valid <= 1'b0;
			tx_wait       <= 0;
		end else if (!text_ch.valid || text_ch.ready) begin
			if (tx_wait > 0) begin
				text_ch.valid <= 1'b0;
				tx_wait       <= tx_wait - 1;
			end else if (text_pend.size() != 0) begin
				tx_next = text_pend.pop_front();
				text_ch.valid   <= 1'b1;
				text_ch.in_byte <= tx_next.b;
				tx_wait         <= tx_next.gap;
			end else begin
				text_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rx_wait      <= 0;
		end else if (hold_req && !hold_done) begin
			hold_done    <= 1'b1;
			res_ch.ready <= 1'b0;
			rx_wait      <= LONG_HOLD;
		end else if (res_ch.ready) begin
			if (res_ch.valid) begin
				rx_gap = rx_fast ? 0 : $urandom_range(0, 16);
				if (rx_gap != 0) begin
					res_ch.ready <= 1'b0;
					rx_wait      <= rx_gap;
				end
			end
		end else if (rx_wait > 1) begin
			rx_wait <= rx_wait - 1;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (text_ch.valid && text_ch.ready) begin
				decode_byte(text_ch.in_byte);
				items_sent++;
			end
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					fails++;
					$display("%0t: unexpected result, got byte %02h kind %0d len %0d last %0b",
						$time, res_ch.out_byte, res_ch.kind, res_ch.str_length, res_ch.last);
				end else begin
					want = expected_results.pop_front();
					if (res_ch.out_byte !== want.b || res_ch.kind !== want.kind ||
						res_ch.str_length !== want.len || res_ch.last !== want.last) begin
						fails++;
						$display("%0t: expected byte %02h kind %0d len %0d last %0b, %s",
							$time, want.b, want.kind, want.len, want.last,
							$sformatf("got byte %02h kind %0d len %0d last %0b",
							res_ch.out_byte, res_ch.kind, res_ch.str_length, res_ch.last));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, expected_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

// ----- filelist.f -----
rtl/jsu_pkg.sv
rtl/jsu_ifs.sv
rtl/jsu_decode.sv
rtl/jsu_serializer.sv
rtl/json_string_unescaper_unit.sv
test/json_string_unescaper_unit_tb.sv
